/* rtl/kpi_pkg.sv */
// ----------------------------------------------------------------------------
// kpi_pkg: shared types for the keyframe pose interpolator
// Keyframe word layout and the control bundle sent to every chain cell.
// ----------------------------------------------------------------------------
`default_nettype none

package kpi_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOOP_ENABLE = 2'd0;
  localparam logic [1:0] CFG_AUTO_START  = 2'd1;
  localparam logic [1:0] CFG_YAW_OFFSET  = 2'd2;

  // Input opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Width of the divider steps for u (17 quotient bits, 1.0 = 65536)
  localparam int unsigned U_BITS  = 17;
  localparam logic [16:0] U_ONE   = 17'd65536;

  // One keyframe
  typedef struct packed {
    logic [31:0] ktime;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] hdg;
  } kpi_key_t;

  // Broadcast control for the cell chain
  typedef struct packed {
    logic     ins;   // sorted insert of new_key
    logic     rot;   // rotate the ring by one place toward cell 0
    kpi_key_t new_key;
  } kpi_ctl_t;

endpackage

`default_nettype wire

/* rtl/kpi_cell.sv */
// ----------------------------------------------------------------------------
// kpi_cell: one keyframe slot of the sorted chain
// Takes part in sorted insertion (shifts toward the tail) and in ring
// rotation (shifts toward the head) used to stream keys out for a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module kpi_cell
  import kpi_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  kpi_ctl_t  ctl_i,
  input  kpi_key_t  prev_key_i,
  input  wire       prev_valid_i,
  input  wire       prev_gt_i,
  input  kpi_key_t  next_key_i,
  input  wire       next_valid_i,
  output kpi_key_t  key_o,
  output logic      valid_o,
  output logic      gt_o
);

  kpi_key_t key_q, key_d;
  logic     valid_q, valid_d;

  // Slot lies after the insertion point: empty or later time
  assign gt_o = !valid_q || (key_q.ktime > ctl_i.new_key.ktime);

  // Next slot contents
  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (ctl_i.rot) begin
      key_d   = next_key_i;
      valid_d = next_valid_i;
    end else if (ctl_i.ins && gt_o) begin
      if (prev_gt_i) begin
        key_d   = prev_key_i;
        valid_d = prev_valid_i;
      end else begin
        key_d   = ctl_i.new_key;
        valid_d = 1'b1;
      end
    end
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Key payload
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

/* rtl/keyframe_pose_interpolator.sv */
// Load word: accepted while idle, busy stays low. Tick word with two or more keys:
// busy through the modulo (loop mode with nonzero duration only), chain scan,
// u divide, shared multiplier (4 channels) and output states; out_valid_o strobes
// in the last busy cycle and the next word is taken in the cycle after. One tick at a
// time; the receiver cannot stall.
// Reset clears key count, start latch, slot valid flags and config; payloads are not reset.
// ----------------------------------------------------------------------------
// keyframe_pose_interpolator: keyframe trajectory with pose interpolation
// Sorted chain of keyframe cells plus a sequencer for time wrap, segment
// scan, u division and linear / shortest-way heading interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_pose_interpolator
  import kpi_pkg::*;
#(
  parameter int unsigned MAX_KEYS = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire                cfg_we_i,
  input  wire  [1:0]         cfg_idx_i,
  input  wire  [15:0]        cfg_data_i,
  input  wire                op_i,
  input  wire  [31:0]        key_time_i,
  input  wire  signed [31:0] key_x_i,
  input  wire  signed [31:0] key_y_i,
  input  wire  signed [31:0] key_z_i,
  input  wire  signed [15:0] key_heading_i,
  input  wire  [31:0]        sim_now_i,
  output logic               out_valid_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [15:0] heading_o
);

  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_MOD, ST_SCAN, ST_DIV, ST_MUL, ST_OUT} state_e;

  state_e state_q;

  // Config
  logic        loop_q, auto_q;
  logic [15:0] yoff_q;

  // Bookkeeping
  logic [CW-1:0] cnt_q;
  logic [31:0]   dur_q;
  logic          started_q;
  logic [31:0]   stime_q;

  // Datapath
  logic [31:0]   t_q, dvd_q;
  logic [32:0]   rem_q;
  logic [5:0]    step_q;
  logic [CW-1:0] scan_q;
  logic          found_q;
  kpi_key_t      ka_q, kb_q;
  logic [16:0]   q_q;
  logic [16:0]   u_q;
  logic [1:0]    ch_q;
  logic          ph_q;
  logic signed [50:0] prod_q;
  logic [31:0]   rx_q, ry_q, rz_q;
  logic [15:0]   rh_q;
  logic          ov_q;

  // Chain wiring
  kpi_ctl_t ctl;
  kpi_key_t key_w   [MAX_KEYS];
  logic     valid_w [MAX_KEYS];
  logic     gt_w    [MAX_KEYS];

  logic acc, acc_load, acc_tick;
  assign acc      = start && (state_q == ST_IDLE);
  assign acc_load = acc && (op_i == OP_LOAD) && (cnt_q < CW'(MAX_KEYS));
  assign acc_tick = acc && (op_i == OP_TICK) && (cnt_q >= CW'(2));

  always_comb begin
    ctl.ins             = acc_load;
    ctl.rot             = (state_q == ST_SCAN);
    ctl.new_key.ktime   = key_time_i;
    ctl.new_key.x       = key_x_i;
    ctl.new_key.y       = key_y_i;
    ctl.new_key.z       = key_z_i;
    ctl.new_key.hdg     = key_heading_i;
  end

  // Cell chain: insert shifts toward the tail, scan rotates toward cell 0
  for (genvar k = 0; k < MAX_KEYS; k++) begin : g_cell
    localparam int unsigned KP = (k == 0) ? 0 : k - 1;
    localparam int unsigned KN = (k + 1) % MAX_KEYS;
    kpi_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .prev_key_i   (key_w[KP]),
      .prev_valid_i ((k == 0) ? 1'b0 : valid_w[KP]),
      .prev_gt_i    ((k == 0) ? 1'b0 : gt_w[KP]),
      .next_key_i   (key_w[KN]),
      .next_valid_i (valid_w[KN]),
      .key_o        (key_w[k]),
      .valid_o      (valid_w[k]),
      .gt_o         (gt_w[k])
    );
  end

  // Elapsed time at tick accept
  logic [31:0] base, elapsed;
  always_comb begin
    if (auto_q) begin
      base = started_q ? stime_q : sim_now_i;
    end else begin
      base = '0;
    end
    elapsed = sim_now_i - base;
  end

  // Modulo step (restoring, one dividend bit per cycle)
  logic [32:0] mrem;
  assign mrem = {rem_q[31:0], dvd_q[31]};

  // u divide step
  logic        dcmp;
  logic [32:0] dspan, dsub;
  logic [31:0] span;
  assign span  = (kb_q.ktime > ka_q.ktime) ? (kb_q.ktime - ka_q.ktime) : 32'd1;
  assign dspan = {1'b0, span};
  assign dcmp  = (rem_q >= dspan);
  assign dsub  = dcmp ? (rem_q - dspan) : rem_q;

  // Channel operands for the shared multiplier
  logic signed [32:0] dsel;
  logic signed [15:0] dyaw;
  assign dyaw = $signed(kb_q.hdg - ka_q.hdg);
  always_comb begin
    unique case (ch_q)
      2'd0:    dsel = $signed({kb_q.x[31], kb_q.x}) - $signed({ka_q.x[31], ka_q.x});
      2'd1:    dsel = $signed({kb_q.y[31], kb_q.y}) - $signed({ka_q.y[31], ka_q.y});
      2'd2:    dsel = $signed({kb_q.z[31], kb_q.z}) - $signed({ka_q.z[31], ka_q.z});
      default: dsel = 33'(dyaw);
    endcase
  end

  logic signed [50:0] rnd;
  logic [31:0]        scl;
  assign rnd = prod_q + 51'sd32768;
  assign scl = 32'(rnd >>> 16);

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q <= 1'b1;
      auto_q <= 1'b1;
      yoff_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOOP_ENABLE: loop_q <= cfg_data_i[0];
        CFG_AUTO_START:  auto_q <= cfg_data_i[0];
        CFG_YAW_OFFSET:  yoff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      dur_q     <= '0;
      started_q <= 1'b0;
      stime_q   <= '0;
      ov_q      <= 1'b0;
    end else begin
      ov_q <= (state_q == ST_MUL) && (ch_q == 2'd3) && ph_q;
      unique case (state_q)
        ST_IDLE: begin
          if (acc_load) begin
            cnt_q <= cnt_q + CW'(1);
            if (key_time_i > dur_q || cnt_q == '0) dur_q <= key_time_i;
          end
          if (acc_tick) begin
            if (auto_q && !started_q) begin
              started_q <= 1'b1;
              stime_q   <= sim_now_i;
            end
            if (loop_q && dur_q != '0) begin
              state_q <= ST_MOD;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_MOD: begin
          if (step_q == 6'd31) state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_q == CW'(MAX_KEYS - 1)) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_q == 6'(U_BITS)) state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (ch_q == 2'd3 && ph_q) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        step_q  <= '0;
        scan_q  <= '0;
        found_q <= 1'b0;
        ch_q    <= '0;
        ph_q    <= 1'b0;
        rem_q   <= '0;
        dvd_q   <= elapsed;
        t_q     <= (elapsed > dur_q) ? dur_q : elapsed;
      end
      ST_MOD: begin
        rem_q  <= (mrem >= {1'b0, dur_q}) ? (mrem - {1'b0, dur_q}) : mrem;
        dvd_q  <= {dvd_q[30:0], 1'b0};
        step_q <= step_q + 6'd1;
        if (step_q == 6'd31) begin
          t_q <= (mrem >= {1'b0, dur_q}) ? 32'(mrem - {1'b0, dur_q}) : mrem[31:0];
        end
      end
      ST_SCAN: begin
        // key at cell 0 is entry scan_q; valid marks entries below count
        scan_q <= scan_q + CW'(1);
        step_q <= '0;
        if (scan_q == '0) begin
          ka_q <= key_w[0];
          kb_q <= key_w[0];
        end else if (valid_w[0] && !found_q) begin
          kb_q <= key_w[0];
          if (key_w[0].ktime < t_q) begin
            ka_q <= key_w[0];
          end else begin
            found_q <= 1'b1;
          end
        end
        rem_q <= '0;
      end
      ST_DIV: begin
        if (step_q == '0) begin
          // first step works on t - tA directly
          if (t_q > ka_q.ktime) begin
            rem_q <= {1'b0, t_q - ka_q.ktime};
          end else begin
            rem_q <= '0;
          end
          q_q    <= '0;
          step_q <= 6'd1;
        end else begin
          q_q    <= {q_q[15:0], dcmp};
          rem_q  <= {dsub[31:0], 1'b0};
          step_q <= step_q + 6'd1;
        end
        if (step_q == 6'(U_BITS)) begin
          u_q <= ({q_q[15:0], dcmp} > U_ONE) ? U_ONE : {q_q[15:0], dcmp};
        end
      end
      ST_MUL: begin
        ph_q <= !ph_q;
        if (!ph_q) begin
          prod_q <= dsel * $signed({1'b0, u_q});
        end else begin
          ch_q <= ch_q + 2'd1;
          unique case (ch_q)
            2'd0:    rx_q <= ka_q.x + scl;
            2'd1:    ry_q <= ka_q.y + scl;
            2'd2:    rz_q <= ka_q.z + scl;
            default: rh_q <= ka_q.hdg + scl[15:0] + yoff_q;
          endcase
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  // u divide: step 0 loads t - tA, steps 1..17 each give one quotient bit,
  // integer bit first, so u has 17 bits with 1.0 = 65536.

  assign busy        = (state_q != ST_IDLE);
  assign out_valid_o = ov_q;
  assign pos_x_o     = rx_q;
  assign pos_y_o     = ry_q;
  assign pos_z_o     = rz_q;
  assign heading_o   = rh_q;

endmodule

`default_nettype wire
